// ===== src/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Shared defaults, field widths and request/status codes.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned MAP_BITS_DEF  = 32768;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned TOTAL_RESET   = 32768;

  localparam int unsigned CNT_W  = 16;
  localparam int unsigned BASE_W = 15;
  localparam int unsigned KIND_W = 2;
  localparam int unsigned STAT_W = 2;

  localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

endpackage

// ===== src/bba_div.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator index split
// Splits a block index into the map word address and the bit position inside
// that word for a power-of-two word size. Registered, done in the cycle after
// start.
// ----------------------------------------------------------------------------
module bba_div #(
  parameter int unsigned DVD_W = 15,
  parameter int unsigned DVSR  = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [DVD_W-1:0]           dividend_i,
  output logic                       done_o,
  output logic [DVD_W-1:0]           quot_o,
  output logic [$clog2(DVSR)-1:0]    rem_o
);

  localparam int unsigned SH = $clog2(DVSR);

  logic             done_q;
  logic [DVD_W-1:0] quot_q;
  logic [SH-1:0]    rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i >> SH;
      rem_q  <= dividend_i[SH-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ===== src/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// Bitmap block allocator
// First-fit allocator over a used-bit map held in one synchronous memory,
// with a saturating free-block counter and an APB register port.
// ----------------------------------------------------------------------------
// Allocate: one map word read per cycle, stopping at the first free bit.
//   Bad free and unknown kind go straight to the result state.
// Throughput: one transaction in flight; the input reopens as the result
//   register loads, and a stalled result holds the next one in S_RESP.
// Reset: map swept to zero one word at a time with s_axis_tready low.
module bitmap_block_allocator import bba_pkg::*; #(
  parameter int unsigned MAP_BITS  = MAP_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,   // [15:0] block_number
  input  logic [1:0]         s_axis_tuser,   // [1:0] kind
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [31:0]        m_axis_tdata,   // [15:0] allocated_block, [31:16] free_count
  output logic [1:0]         m_axis_tuser,   // [1:0] status
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned BW    = $clog2(WORD_BITS);
  localparam int unsigned IDX_W = $clog2(MAP_BITS);
  localparam int unsigned SB_W  = CNT_W + 1;
  localparam int unsigned RESET_CNT_I = (TOTAL_RESET > MAP_BITS) ? MAP_BITS : TOTAL_RESET;
  localparam logic [CNT_W-1:0] RESET_CNT = CNT_W'(RESET_CNT_I);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FRD  = 3'd4;
  localparam logic [2:0] S_FCHK = 3'd5;
  localparam logic [2:0] S_RESP = 3'd6;

  // registers
  logic [CNT_W-1:0]  total_q;
  logic [BASE_W-1:0] base_q;
  logic [CNT_W-1:0]  free_cnt_q;
  logic [2:0]        state_q, state_d;
  logic [SB_W-1:0]   iss_base_q, chk_base_q;
  logic [AW-1:0]     iss_word_q, chk_word_q, clr_addr_q;
  logic              rv_q;
  logic              clr_resp_q;
  logic [CNT_W-1:0]  res_alloc_q;
  logic [STAT_W-1:0] res_status_q;
  logic              m_valid_q;
  logic [31:0]       m_data_q;
  logic [1:0]        m_user_q;

  // map memory
  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [WORD_BITS-1:0] rdata_q;
  logic                 re, we;
  logic [AW-1:0]        raddr, waddr;
  logic [WORD_BITS-1:0] wdata;

  // datapath
  logic [CNT_W-1:0]     limit;
  logic                 accept;
  logic [CNT_W-1:0]     base_ext;
  logic [CNT_W-1:0]     idx_raw;
  logic                 free_bad;
  logic [SB_W-1:0]      room;
  logic [WORD_BITS-1:0] avail;
  logic [BW-1:0]        pos;
  logic                 hit;
  logic                 issue;
  logic [CNT_W-1:0]     hit_idx;
  logic                 resp_go;
  logic                 clr_last;
  logic                 div_start, div_done;
  logic [IDX_W-1:0]     div_quot;
  logic [BW-1:0]        div_rem;

  // register port
  assign pready = 1'b1;

  always_comb begin
    if (paddr[2]) begin
      prdata = {{(32 - BASE_W){1'b0}}, base_q};
    end else begin
      prdata = {{(32 - CNT_W){1'b0}}, total_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= CNT_W'(TOTAL_RESET);
      base_q  <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[2]) begin
        base_q <= pwdata[BASE_W-1:0];
      end else begin
        total_q <= pwdata[CNT_W-1:0];
      end
    end
  end

  assign limit = ({1'b0, total_q} > SB_W'(MAP_BITS)) ? CNT_W'(MAP_BITS) : total_q;

  // request decode
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign base_ext      = {1'b0, base_q};
  assign idx_raw       = s_axis_tdata - base_ext;
  assign free_bad      = (s_axis_tdata < base_ext) || (idx_raw >= limit);
  assign div_start     = accept && (s_axis_tuser == KIND_FREE) && !free_bad;

  bba_div #(
    .DVD_W (IDX_W),
    .DVSR  (WORD_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (idx_raw[IDX_W-1:0]),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // first-fit search over the word in rdata_q
  assign room = SB_W'(limit) - chk_base_q;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      avail[j] = !rdata_q[j] && (SB_W'(j) < room);
    end
  end

  always_comb begin
    pos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        pos = BW'(j);
      end
    end
  end

  assign hit      = (state_q == S_SCAN) && rv_q && (|avail);
  assign issue    = (state_q == S_SCAN) && (iss_base_q < SB_W'(limit)) && !hit;
  assign hit_idx  = chk_base_q[CNT_W-1:0] + CNT_W'(pos);
  assign resp_go  = (state_q == S_RESP) && (!m_valid_q || m_axis_tready);
  assign clr_last = (clr_addr_q == AW'(MAP_WORDS - 1));

  // memory ports
  always_comb begin
    re    = issue || (state_q == S_FRD);
    raddr = (state_q == S_FRD) ? div_quot[AW-1:0] : iss_word_q;
    we    = 1'b0;
    waddr = clr_addr_q;
    wdata = '0;
    unique case (state_q)
      S_CLR: begin
        we = 1'b1;
      end
      S_SCAN: begin
        we    = hit;
        waddr = chk_word_q;
        wdata = rdata_q | (WORD_BITS'(1) << pos);
      end
      S_FCHK: begin
        we    = rdata_q[div_rem];
        waddr = div_quot[AW-1:0];
        wdata = rdata_q & ~(WORD_BITS'(1) << div_rem);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (s_axis_tuser)
            KIND_ALLOC: state_d = S_SCAN;
            KIND_FREE:  state_d = free_bad ? S_RESP : S_DIV;
            KIND_CLEAR: state_d = S_CLR;
            default:    state_d = S_RESP;
          endcase
        end
      end
      S_CLR: begin
        if (clr_last) begin
          state_d = clr_resp_q ? S_RESP : S_IDLE;
        end
      end
      S_SCAN: begin
        if (hit || (!rv_q && !issue)) begin
          state_d = S_RESP;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_FRD;
        end
      end
      S_FRD:  state_d = S_FCHK;
      S_FCHK: state_d = S_RESP;
      S_RESP: begin
        if (resp_go) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLR;
      clr_addr_q   <= '0;
      clr_resp_q   <= 1'b0;
      free_cnt_q   <= RESET_CNT;
      rv_q         <= 1'b0;
      iss_base_q   <= '0;
      iss_word_q   <= '0;
      res_status_q <= STAT_OK;
      m_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= issue;

      if (accept) begin
        res_alloc_q  <= '0;
        res_status_q <= ((s_axis_tuser == KIND_FREE) && free_bad) ? STAT_BAD : STAT_OK;
        iss_base_q   <= '0;
        iss_word_q   <= '0;
        clr_addr_q   <= '0;
        clr_resp_q   <= 1'b1;
      end

      if (state_q == S_CLR) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_last && clr_resp_q) begin
          free_cnt_q <= limit;
        end
      end

      if (issue) begin
        iss_base_q <= iss_base_q + SB_W'(WORD_BITS);
        iss_word_q <= iss_word_q + AW'(1);
        chk_base_q <= iss_base_q;
        chk_word_q <= iss_word_q;
      end

      if (hit) begin
        res_alloc_q <= hit_idx + base_ext;
        if (free_cnt_q != '0) begin
          free_cnt_q <= free_cnt_q - CNT_W'(1);
        end
      end else if ((state_q == S_SCAN) && !rv_q && !issue) begin
        res_status_q <= STAT_FULL;
      end

      if ((state_q == S_FCHK) && rdata_q[div_rem] && (free_cnt_q < limit)) begin
        free_cnt_q <= free_cnt_q + CNT_W'(1);
      end

      if (resp_go) begin
        m_valid_q <= 1'b1;
        m_data_q  <= {free_cnt_q, res_alloc_q};
        m_user_q  <= res_status_q;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule
